[src/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 inverse core
// Widths of the fixed-point datapath and the det stage status bundle.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int ELEM_W        = 32;   // one Q element
    localparam int NUM_EL        = 9;    // elements per matrix
    localparam int DATA_W        = ELEM_W * NUM_EL;
    localparam int MINOR_W       = 65;   // exact 2x2 minor, signed
    localparam int DET_W         = 97;   // exact determinant, signed
    localparam int MAG_W         = 96;   // determinant magnitude
    localparam int QUO_W         = 32;   // quotient bits kept by a lane
    localparam int THR_W         = 31;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [THR_W-1:0] THR_RESET = 31'd655;

    typedef logic [NUM_EL-1:0][MINOR_W-1:0] minor_arr_t;

    typedef struct packed {
        logic             valid;
        logic             singular;
        logic             det_neg;
        logic [MAG_W-1:0] dmag;
    } det_info_t;

endpackage

[src/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det: minors, determinant and singular test
// Eight stages: capture, products, minors, split products, terms, sum,
// magnitude, threshold compare.
// ----------------------------------------------------------------------------
module mi3_det
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    input  logic [THR_W-1:0]  thr,
    output det_info_t         info,
    output minor_arr_t        minors
);

    logic [7:0]               v_reg;
    logic signed [ELEM_W-1:0] m_reg   [NUM_EL];
    logic signed [63:0]       pa_reg  [NUM_EL];
    logic signed [63:0]       pb_reg  [NUM_EL];
    logic signed [ELEM_W-1:0] e2_reg  [3];
    logic signed [ELEM_W-1:0] e3_reg  [3];
    logic [MINOR_W-1:0]       mn3_reg [NUM_EL];
    logic [MINOR_W-1:0]       mn4_reg [NUM_EL];
    logic [MINOR_W-1:0]       mn5_reg [NUM_EL];
    logic [MINOR_W-1:0]       mn6_reg [NUM_EL];
    logic [MINOR_W-1:0]       mn7_reg [NUM_EL];
    logic [MINOR_W-1:0]       mn8_reg [NUM_EL];
    logic signed [63:0]       pph_reg [3];
    logic signed [65:0]       ppl_reg [3];
    logic signed [DET_W-1:0]  t5_reg  [3];
    logic signed [DET_W-1:0]  det6_reg;
    logic [DET_W-1:0]         det_neg6;
    logic [MAG_W-1:0]         dmag7_reg;
    logic                     dneg7_reg;
    logic [MAG_W-1:0]         dmag8_reg;
    logic                     dneg8_reg;
    logic                     sing8_reg;
    logic [MAG_W-1:0]         limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_EL; k++)
        begin : g_el
            localparam int R  = k / 3;
            localparam int C  = k % 3;
            localparam int Y1 = (R == 0) ? 1 : 0;
            localparam int Y2 = (R == 2) ? 1 : 2;
            localparam int X1 = (C == 0) ? 1 : 0;
            localparam int X2 = (C == 2) ? 1 : 2;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    m_reg[k]   <= $signed(in_data[k*ELEM_W +: ELEM_W]);
                    pa_reg[k]  <= m_reg[Y1*3+X1] * m_reg[Y2*3+X2];
                    pb_reg[k]  <= m_reg[Y1*3+X2] * m_reg[Y2*3+X1];
                    mn3_reg[k] <= {pa_reg[k][63], pa_reg[k]} - {pb_reg[k][63], pb_reg[k]};
                    mn4_reg[k] <= mn3_reg[k];
                    mn5_reg[k] <= mn4_reg[k];
                    mn6_reg[k] <= mn5_reg[k];
                    mn7_reg[k] <= mn6_reg[k];
                    mn8_reg[k] <= mn7_reg[k];
                end
            end
            assign minors[k] = mn8_reg[k];
        end

        // Row 0 expansion: split each minor into a signed high and unsigned low half
        for (k = 0; k < 3; k++)
        begin : g_row0
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    e2_reg[k]  <= m_reg[k];
                    e3_reg[k]  <= e2_reg[k];
                    pph_reg[k] <= e3_reg[k] * $signed(mn3_reg[k][64:33]);
                    ppl_reg[k] <= e3_reg[k] * $signed({1'b0, mn3_reg[k][32:0]});
                    t5_reg[k]  <= $signed({pph_reg[k], 33'b0})
                                + $signed({{31{ppl_reg[k][65]}}, ppl_reg[k]});
                end
            end
        end
    endgenerate

    assign det_neg6 = -det6_reg;
    assign limit    = MAG_W'({thr, {(2*FRAC_BITS){1'b0}}});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det6_reg  <= t5_reg[0] - t5_reg[1] + t5_reg[2];
            dneg7_reg <= det6_reg[DET_W-1];
            dmag7_reg <= det6_reg[DET_W-1] ? det_neg6[MAG_W-1:0] : det6_reg[MAG_W-1:0];
            dneg8_reg <= dneg7_reg;
            dmag8_reg <= dmag7_reg;
            sing8_reg <= (dmag7_reg == '0) || (dmag7_reg < limit);
        end
    end

    assign info.valid    = v_reg[7];
    assign info.singular = sing8_reg;
    assign info.det_neg  = dneg8_reg;
    assign info.dmag     = dmag8_reg;

endmodule

[src/mi3_lane.sv]
// ----------------------------------------------------------------------------
// mi3_lane: one output element of the inverse
// Magnitude, overflow check, then a 32-stage restoring divider and
// saturation to a signed 32-bit result.
// ----------------------------------------------------------------------------
module mi3_lane
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               adv,
    input  logic [MINOR_W-1:0] mnr,
    input  logic               flip,
    input  logic               det_neg,
    input  logic [MAG_W-1:0]   dmag,
    output logic [QUO_W-1:0]   value
);

    localparam int NW = 64 + 2 * FRAC_BITS;

    logic [63:0]        am_reg;
    logic               neg0_reg;
    logic [MAG_W-1:0]   dm0_reg;
    logic [MINOR_W-1:0] mnr_neg;
    logic [NW-1:0]      num;

    logic [MAG_W-1:0]   r_reg   [QUO_W+1];
    logic [QUO_W-1:0]   nb_reg  [QUO_W+1];
    logic [QUO_W-1:0]   q_reg   [QUO_W+1];
    logic [MAG_W-1:0]   dm_reg  [QUO_W+1];
    logic               neg_reg [QUO_W+1];
    logic               ovf_reg [QUO_W+1];

    assign mnr_neg = -mnr;
    assign num     = {am_reg, {(2*FRAC_BITS){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            am_reg     <= mnr[MINOR_W-1] ? mnr_neg[63:0] : mnr[63:0];
            neg0_reg   <= mnr[MINOR_W-1] ^ det_neg ^ flip;
            dm0_reg    <= dmag;
            // quotient reaches 2^32 exactly when the upper numerator part is >= divisor
            ovf_reg[0] <= MAG_W'(num[NW-1:QUO_W]) >= dm0_reg;
            r_reg[0]   <= MAG_W'(num[NW-1:QUO_W]);
            nb_reg[0]  <= num[QUO_W-1:0];
            q_reg[0]   <= '0;
            dm_reg[0]  <= dm0_reg;
            neg_reg[0] <= neg0_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_div
            logic [MAG_W:0] trial;
            logic [MAG_W:0] diff;
            logic           ge;

            assign trial = {r_reg[k], nb_reg[k][QUO_W-1]};
            assign diff  = trial - {1'b0, dm_reg[k]};
            assign ge    = trial >= {1'b0, dm_reg[k]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_reg[k+1]   <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                    nb_reg[k+1]  <= {nb_reg[k][QUO_W-2:0], 1'b0};
                    q_reg[k+1]   <= {q_reg[k][QUO_W-2:0], ge};
                    dm_reg[k+1]  <= dm_reg[k];
                    neg_reg[k+1] <= neg_reg[k];
                    ovf_reg[k+1] <= ovf_reg[k];
                end
            end
        end
    endgenerate

    // Saturate to the signed range
    always_comb
    begin
        if (!neg_reg[QUO_W])
        begin
            if (ovf_reg[QUO_W] || q_reg[QUO_W][QUO_W-1])
                value = 32'h7FFF_FFFF;
            else
                value = q_reg[QUO_W];
        end
        else
        begin
            if (ovf_reg[QUO_W] || (q_reg[QUO_W] > 32'h8000_0000))
                value = 32'h8000_0000;
            else
                value = -q_reg[QUO_W];
        end
    end

endmodule

[src/mi3_merge.sv]
// ----------------------------------------------------------------------------
// mi3_merge: combine lane results into one output transfer
// Zero all elements and clear ok for a singular matrix; hold while stalled.
// ----------------------------------------------------------------------------
module mi3_merge
    import mi3_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          singular,
    input  logic [NUM_EL-1:0][QUO_W-1:0]  lane_val,
    output logic                          adv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [DATA_W-1:0]             out_data,
    output logic                          out_ok
);

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic              ok_reg;

    assign adv = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= singular ? '0 : DATA_W'(lane_val);
            ok_reg   <= !singular;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_ok    = ok_reg;

endmodule

[src/matrix3x3_inverse_core.sv]
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core: 3x3 matrix inverse by the adjugate method
// Slave stream carries one signed fixed-point matrix per transfer; master
// stream returns the nine inverse elements and an ok flag in tuser. A
// matrix whose determinant magnitude is below det_threshold (or zero)
// yields all zeros with ok cleared. Results saturate to 32-bit signed.
// Throughput: one matrix per cycle while not stalled. From input transfer
// to m_tvalid: 8 determinant stages, 2 lane setup stages, 32 stages of the
// restoring divider in each of nine parallel lanes, and the output register.
// The whole pipeline advances together: when the receiver stalls with a
// result held, s_tready drops and every stage holds; while the output
// register is empty or being taken, a new matrix is accepted each cycle.
// Reset empties the pipeline and loads det_threshold with 655 (about 0.01).
// User writes det_threshold through cfg_wen/cfg_wdata while idle; unchecked.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // inv00 inv01 inv02 inv10 .. inv22
    output logic [0:0]        m_tuser,   // ok
    input  logic              cfg_wen,
    input  logic [THR_W-1:0]  cfg_wdata
);

    localparam int LANE_LAT = QUO_W + 2;

    logic                         adv;
    logic [THR_W-1:0]             thr_reg;
    det_info_t                    info;
    minor_arr_t                   minors;
    logic [LANE_LAT-1:0]          lv_reg;
    logic [LANE_LAT-1:0]          ls_reg;
    logic [NUM_EL-1:0][QUO_W-1:0] lane_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wen)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .thr      (thr_reg),
        .info     (info),
        .minors   (minors)
    );

    // Carry valid and the singular flag alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg <= '0;
        end
        else if (adv)
        begin
            lv_reg <= {lv_reg[LANE_LAT-2:0], info.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ls_reg <= {ls_reg[LANE_LAT-2:0], info.singular};
        end
    end

    genvar y, x;
    generate
        for (y = 0; y < 3; y++)
        begin : g_row
            for (x = 0; x < 3; x++)
            begin : g_col
                mi3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane
                (
                    .clk     (clk),
                    .adv     (adv),
                    .mnr     (minors[x*3+y]),
                    .flip    (((x + y) % 2) == 1),
                    .det_neg (info.det_neg),
                    .dmag    (info.dmag),
                    .value   (lane_val[y*3+x])
                );
            end
        end
    endgenerate

    mi3_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lv_reg[LANE_LAT-1]),
        .singular  (ls_reg[LANE_LAT-1]),
        .lane_val  (lane_val),
        .adv       (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_ok    (m_tuser[0])
    );

    assign s_tready = adv;

    a_sing_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("singular result not zeroed");

    a_zero_det : assert property (@(posedge clk) disable iff (!rst_n)
        info.valid && info.dmag == '0 |-> info.singular)
        else $error("zero determinant not flagged singular");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule
